/* hdl/pthc_pkg.sv */
// shared types and constants for the sensor compensation block
`timescale 1ns / 1ps
`default_nettype none
package pthc_pkg;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} sample_t;

	typedef struct packed {
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p5;
		logic [31:0] p6;
		logic [31:0] p7;
		logic [31:0] p8;
		logic [31:0] p9;
		logic [31:0] h1;
		logic [31:0] h2;
		logic [31:0] h3;
		logic [31:0] h4;
		logic [31:0] h5;
		logic [31:0] h6;
	} coef_t;

	typedef struct packed {
		logic [23:0] temperature_centi;
		logic [16:0] humidity_q10;
		logic [31:0] pressure_pa;
		logic        pressure_divisor_zero;
	} result_t;

	localparam logic [2:0] REG_TEMP     = 3'd0;
	localparam logic [2:0] REG_PRESS_LO = 3'd1;
	localparam logic [2:0] REG_PRESS_HI = 3'd2;
	localparam logic [2:0] REG_PRESS_P9 = 3'd3;
	localparam logic [2:0] REG_HUMID    = 3'd4;

	localparam logic [31:0] HUM_OFFSET   = 32'd76800;
	localparam logic [31:0] PRESS_OFFSET = 32'd64000;
	localparam logic [31:0] HUM_MAX      = 32'd419430400;
	localparam logic [31:0] PRESS_BASE   = 32'd1048576;
	localparam logic [31:0] PRESS_SCALE  = 32'd3125;
	localparam logic [31:0] SIGN_BIT     = 32'h80000000;
	localparam logic [31:0] HUM_BIAS     = 32'd2097152;
	localparam logic [31:0] ROUND_14     = 32'd16384;
	localparam logic [31:0] ONE_15       = 32'd32768;
	localparam logic [31:0] ROUND_13     = 32'd8192;
	localparam int          QDEPTH       = 4;
	localparam int          DIV_STEPS    = 32;

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		asr = 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

/* hdl/pthc_front.sv */
// front end: calibration registers, temperature and humidity, pressure terms
`timescale 1ns / 1ps
`default_nettype none
module pthc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [5:0]          paddr,
	input  wire logic [63:0]         pwdata,
	output logic [63:0]              prdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pthc_pkg::sample_t   in_data,
	output logic                     fr_valid,
	input  wire logic                fr_ready,
	output logic [31:0]              fr_num,
	output logic [31:0]              fr_den,
	output logic [23:0]              fr_temp,
	output logic [16:0]              fr_hum,
	output pthc_pkg::coef_t          fr_coef
);
	import pthc_pkg::*;

	logic [47:0] temp_calib_q;
	logic [63:0] press_lo_q, press_hi_q, humid_q;
	logic [15:0] p9_q;
	coef_t c;
	logic [2:0] ridx;

	assign ridx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_lo_q <= '0;
			press_hi_q <= '0;
			p9_q <= '0;
			humid_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_TEMP:     temp_calib_q <= pwdata[47:0];
				REG_PRESS_LO: press_lo_q <= pwdata;
				REG_PRESS_HI: press_hi_q <= pwdata;
				REG_PRESS_P9: p9_q <= pwdata[15:0];
				REG_HUMID:    humid_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_TEMP:     prdata = {16'd0, temp_calib_q};
			REG_PRESS_LO: prdata = press_lo_q;
			REG_PRESS_HI: prdata = press_hi_q;
			REG_PRESS_P9: prdata = {48'd0, p9_q};
			REG_HUMID:    prdata = humid_q;
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		c.t1 = {16'd0, temp_calib_q[15:0]};
		c.t2 = sx16(temp_calib_q[31:16]);
		c.t3 = sx16(temp_calib_q[47:32]);
		c.p1 = {16'd0, press_lo_q[15:0]};
		c.p2 = sx16(press_lo_q[31:16]);
		c.p3 = sx16(press_lo_q[47:32]);
		c.p4 = sx16(press_lo_q[63:48]);
		c.p5 = sx16(press_hi_q[15:0]);
		c.p6 = sx16(press_hi_q[31:16]);
		c.p7 = sx16(press_hi_q[47:32]);
		c.p8 = sx16(press_hi_q[63:48]);
		c.p9 = sx16(p9_q);
		c.h1 = {24'd0, humid_q[7:0]};
		c.h2 = sx16(humid_q[23:8]);
		c.h3 = {24'd0, humid_q[31:24]};
		c.h4 = {{20{humid_q[43]}}, humid_q[43:32]};
		c.h5 = {{20{humid_q[55]}}, humid_q[55:44]};
		c.h6 = {{24{humid_q[63]}}, humid_q[63:56]};
	end

	// pipeline: 10 stages
	localparam int NS = 10;
	logic [NS-1:0] v_q;
	logic adv;
	assign adv = !v_q[NS-1] || fr_ready;
	assign in_ready = adv;
	assign fr_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS-2:0], in_valid};
	end

	// stage 1
	logic [31:0] ta_s1, d_s1, ap_s1, ah_s1;
	// stage 2
	logic [31:0] ta_s2, dd_s2, ap_s2, ah_s2;
	// stage 3
	logic [31:0] tf_s3, ap_s3, ah_s3;
	// stage 4
	logic [31:0] pa_s4, pq_s4, ap_s4, ah_s4, t5_s4, hx5_s4, x6_s4, x3_s4;
	// stage 5
	logic [31:0] temp_s5, pqq_s5, ap_s5, ha_s5, hb_s5, ap5_s5, p2a_s5;
	// stage 6
	logic [31:0] temp_s6, ap_s6, ha_s6, hb_s6, b6_s6, p3q_s6, p2a_s6;
	// stage 7
	logic [31:0] temp_s7, ap_s7, ha_s7, hb_s7, pb_s7, pa_s7;
	// stage 8
	logic [31:0] temp_s8, ap_s8, hx_s8, pb_s8, pa_s8;
	// stage 9
	logic [31:0] temp_s9, ap_s9, hx_s9, hqq_s9, pb_s9, den_s9;
	// stage 10
	logic [31:0] temp_s10, hum_s10, num_s10, den_s10;

	logic [31:0] at, hq, hy;
	assign at = {12'd0, in_data.raw_temperature};

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s1 <= (at >> 3) - (c.t1 << 1);
			d_s1 <= (at >> 4) - c.t1;
			ap_s1 <= {12'd0, in_data.raw_pressure};
			ah_s1 <= {16'd0, in_data.raw_humidity};

			ta_s2 <= asr(ta_s1 * c.t2, 11);
			dd_s2 <= asr(d_s1 * d_s1, 12);
			ap_s2 <= ap_s1;
			ah_s2 <= ah_s1;

			tf_s3 <= ta_s2 + asr(dd_s2 * c.t3, 14);
			ap_s3 <= ap_s2;
			ah_s3 <= ah_s2;

			pa_s4 <= asr(tf_s3, 1) - PRESS_OFFSET;
			pq_s4 <= asr(asr(tf_s3, 1) - PRESS_OFFSET, 2);
			ap_s4 <= ap_s3;
			ah_s4 <= ah_s3;
			t5_s4 <= tf_s3 * 32'd5;
			hx5_s4 <= c.h5 * (tf_s3 - HUM_OFFSET);
			x6_s4 <= asr((tf_s3 - HUM_OFFSET) * c.h6, 10);
			x3_s4 <= asr((tf_s3 - HUM_OFFSET) * c.h3, 11) + ONE_15;

			temp_s5 <= asr(t5_s4 + 32'd128, 8);
			pqq_s5 <= pq_s4 * pq_s4;
			ap_s5 <= ap_s4;
			ha_s5 <= asr((ah_s4 << 14) - (c.h4 << 20) - hx5_s4 + ROUND_14, 15);
			hb_s5 <= x6_s4 * x3_s4;
			ap5_s5 <= (pa_s4 * c.p5) << 1;
			p2a_s5 <= asr(c.p2 * pa_s4, 1);

			temp_s6 <= temp_s5;
			ap_s6 <= ap_s5;
			ha_s6 <= ha_s5;
			hb_s6 <= (asr(hb_s5, 10) + HUM_BIAS) * c.h2 + ROUND_13;
			b6_s6 <= asr(pqq_s5, 11) * c.p6 + ap5_s5;
			p3q_s6 <= asr(c.p3 * asr(pqq_s5, 13), 3);
			p2a_s6 <= p2a_s5;

			temp_s7 <= temp_s6;
			ap_s7 <= ap_s6;
			ha_s7 <= ha_s6;
			hb_s7 <= asr(hb_s6, 14);
			pb_s7 <= asr(b6_s6, 2) + (c.p4 << 16);
			pa_s7 <= asr(p3q_s6 + p2a_s6, 18) + ONE_15;

			temp_s8 <= temp_s7;
			ap_s8 <= ap_s7;
			hx_s8 <= ha_s7 * hb_s7;
			pb_s8 <= pb_s7;
			pa_s8 <= pa_s7 * c.p1;

			temp_s9 <= temp_s8;
			ap_s9 <= ap_s8;
			hx_s9 <= hx_s8;
			hqq_s9 <= asr(asr(hx_s8, 15) * asr(hx_s8, 15), 7);
			pb_s9 <= pb_s8;
			den_s9 <= asr(pa_s8, 15);

			temp_s10 <= temp_s9;
			hum_s10 <= hy;
			num_s10 <= ((PRESS_BASE - ap_s9) - asr(pb_s9, 12)) * PRESS_SCALE;
			den_s10 <= den_s9;
		end
	end

	always_comb begin
		hq = hx_s9 - asr(hqq_s9 * c.h1, 4);
		if (hq[31]) hq = '0;
		if (hq > HUM_MAX) hq = HUM_MAX;
		hy = hq >> 12;
	end

	assign fr_num = num_s10;
	assign fr_den = den_s10;
	assign fr_temp = temp_s10[23:0];
	assign fr_hum = hum_s10[16:0];
	assign fr_coef = c;
endmodule
`default_nettype wire

/* hdl/pthc_queue.sv */
// small fifo between front and back
`timescale 1ns / 1ps
`default_nettype none
module pthc_queue #(
	parameter int W = 8,
	parameter int D = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_valid,
	output logic              wr_ready,
	input  wire logic [W-1:0] wr_data,
	output logic              rd_valid,
	input  wire logic         rd_ready,
	output logic [W-1:0]      rd_data
);
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	logic [W-1:0] mem_q [D];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(D);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(D-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(D-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

/* hdl/pthc_back.sv */
// back end: pipelined divider and final pressure correction
`timescale 1ns / 1ps
`default_nettype none
module pthc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [31:0]       num,
	input  wire logic [31:0]       den,
	input  wire logic [23:0]       temp,
	input  wire logic [16:0]       hum,
	input  wire pthc_pkg::coef_t   coef,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pthc_pkg::result_t      out_data
);
	import pthc_pkg::*;

	localparam int N = DIV_STEPS;
	localparam int NS = N + 5;
	logic [NS-1:0] v_q;
	logic adv;
	assign adv = !v_q[NS-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS-2:0], in_valid};
	end

	// entry 0 holds the set-up dividend, then restoring division one bit per stage
	logic [31:0] rem_q [N+1];
	logic [31:0] quo_q [N+1];
	logic [31:0] dd_q  [N+1];
	logic [31:0] dn_q  [N+1];
	logic [23:0] t_q   [N+1];
	logic [16:0] h_q   [N+1];
	logic        dz_q  [N+1];
	logic        bg_q  [N+1];

	always_ff @(posedge clk) begin
		logic [32:0] r;
		if (adv) begin
			rem_q[0] <= '0;
			quo_q[0] <= '0;
			bg_q[0] <= num >= SIGN_BIT;
			dd_q[0] <= (num < SIGN_BIT) ? (num << 1) : num;
			dn_q[0] <= den;
			dz_q[0] <= den == '0;
			t_q[0] <= temp;
			h_q[0] <= hum;
			for (int i = 0; i < N; i++) begin
				r = {rem_q[i], dd_q[i][N-1-i]};
				if (r >= {1'b0, dn_q[i]}) begin
					rem_q[i+1] <= 32'(r - {1'b0, dn_q[i]});
					quo_q[i+1] <= quo_q[i] | (32'd1 << (N-1-i));
				end else begin
					rem_q[i+1] <= r[31:0];
					quo_q[i+1] <= quo_q[i];
				end
				dd_q[i+1] <= dd_q[i];
				dn_q[i+1] <= dn_q[i];
				t_q[i+1] <= t_q[i];
				h_q[i+1] <= h_q[i];
				dz_q[i+1] <= dz_q[i];
				bg_q[i+1] <= bg_q[i];
			end
		end
	end

	logic [31:0] pr_s1, sq_s1, pb_s1;
	logic [31:0] pr_s2, sq_s2, pb_s2;
	logic [31:0] pr_s3, ab_s3;
	logic [31:0] pr_s4;
	logic [23:0] t_s1, t_s2, t_s3, t_s4;
	logic [16:0] h_s1, h_s2, h_s3, h_s4;
	logic dz_s1, dz_s2, dz_s3, dz_s4;
	logic [31:0] pq;

	assign pq = bg_q[N] ? (quo_q[N] << 1) : quo_q[N];

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s1 <= pq;
			sq_s1 <= (pq >> 3) * (pq >> 3);
			pb_s1 <= asr((pq >> 2) * coef.p8, 13);
			t_s1 <= t_q[N];
			h_s1 <= h_q[N];
			dz_s1 <= dz_q[N];

			pr_s2 <= pr_s1;
			sq_s2 <= asr(coef.p9 * (sq_s1 >> 13), 12);
			pb_s2 <= pb_s1;
			t_s2 <= t_s1;
			h_s2 <= h_s1;
			dz_s2 <= dz_s1;

			pr_s3 <= pr_s2;
			ab_s3 <= asr(sq_s2 + pb_s2 + coef.p7, 4);
			t_s3 <= t_s2;
			h_s3 <= h_s2;
			dz_s3 <= dz_s2;

			pr_s4 <= dz_s3 ? '0 : pr_s3 + ab_s3;
			t_s4 <= t_s3;
			h_s4 <= h_s3;
			dz_s4 <= dz_s3;
		end
	end

	assign out_data.temperature_centi = t_s4;
	assign out_data.humidity_q10 = h_s4;
	assign out_data.pressure_pa = pr_s4;
	assign out_data.pressure_divisor_zero = dz_s4;
endmodule
`default_nettype wire

/* hdl/pth_sensor_compensation.sv */
// top level of the temperature, pressure and humidity compensation block
// a sample passes the front pipeline, then the queue, then the back pipeline
// throughput: one sample per cycle while the output is not stalled; the 32-stage one-bit divider sets the depth
// a stall at the output backs up through the queue to the front
// reset clears all calibration registers to zero and empties every stage
`timescale 1ns / 1ps
`default_nettype none
module pth_sensor_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [19:0] raw_pressure,
	input  wire logic [15:0] raw_humidity,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [23:0]      temperature_centi,
	output logic [16:0]      humidity_q10,
	output logic [31:0]      pressure_pa,
	output logic             pressure_divisor_zero
);
	import pthc_pkg::*;

	localparam int QW = 32 + 32 + 24 + 17;

	sample_t smp;
	coef_t coef;
	result_t res;
	logic fv, fr, qv, qr;
	logic [31:0] fnum, fden;
	logic [23:0] ftemp;
	logic [16:0] fhum;
	logic [QW-1:0] qd;

	assign pready = 1'b1;
	assign smp.raw_temperature = raw_temperature;
	assign smp.raw_pressure = raw_pressure;
	assign smp.raw_humidity = raw_humidity;

	pthc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(smp),
		.fr_valid(fv), .fr_ready(fr), .fr_num(fnum), .fr_den(fden),
		.fr_temp(ftemp), .fr_hum(fhum), .fr_coef(coef)
	);

	pthc_queue #(.W(QW), .D(QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fv), .wr_ready(fr), .wr_data({fnum, fden, ftemp, fhum}),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qd)
	);

	pthc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(qv), .in_ready(qr),
		.num(qd[QW-1 -: 32]), .den(qd[QW-33 -: 32]),
		.temp(qd[40:17]), .hum(qd[16:0]), .coef(coef),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(res)
	);

	assign temperature_centi = res.temperature_centi;
	assign humidity_q10 = res.humidity_q10;
	assign pressure_pa = res.pressure_pa;
	assign pressure_divisor_zero = res.pressure_divisor_zero;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressure_divisor_zero |-> pressure_pa == '0)
		else $error("pressure not zero on zero divisor");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_q10 <= 17'd102400)
		else $error("humidity out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_pa))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

/* bench/pth_sensor_compensation_tb.sv */
// self-checking testbench for the sensor compensation block with its own predictor
`timescale 1ns / 1ps
module pth_sensor_compensation_tb;
	import pthc_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_RANDOM    = 1400;
	localparam int DRAIN       = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [19:0] raw_temperature = '0;
	logic [19:0] raw_pressure = '0;
	logic [15:0] raw_humidity = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [23:0] temperature_centi;
	logic [16:0] humidity_q10;
	logic [31:0] pressure_pa;
	logic        pressure_divisor_zero;

	pth_sensor_compensation DUT (.*);

	always #5 clk = ~clk;

	logic [47:0] temp_cal;
	logic [63:0] press_lo_cal, press_hi_cal, humid_cal;
	logic [15:0] p9_cal;

	sample_t pending_samples[$];
	result_t expected_results[$];
	sample_t cur_sample;
	int      send_gap = 0, recv_stall = 0;
	bit      no_idle = 0;
	int      errors = 0;
	int      cycles = 0;
	bit      busy;

	function automatic logic [31:0] sra(input logic [31:0] v, input int n);
		return $signed(v) >>> n;
	endfunction

	function automatic result_t compensate(input sample_t s);
		logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6, a, b, d, x, q, tf, pres;
		result_t r;
		at = {12'b0, s.raw_temperature};
		ap = {12'b0, s.raw_pressure};
		ah = {16'b0, s.raw_humidity};
		t1 = {16'b0, temp_cal[15:0]};
		t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
		t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
		p1 = {16'b0, press_lo_cal[15:0]};
		p2 = {{16{press_lo_cal[31]}}, press_lo_cal[31:16]};
		p3 = {{16{press_lo_cal[47]}}, press_lo_cal[47:32]};
		p4 = {{16{press_lo_cal[63]}}, press_lo_cal[63:48]};
		p5 = {{16{press_hi_cal[15]}}, press_hi_cal[15:0]};
		p6 = {{16{press_hi_cal[31]}}, press_hi_cal[31:16]};
		p7 = {{16{press_hi_cal[47]}}, press_hi_cal[47:32]};
		p8 = {{16{press_hi_cal[63]}}, press_hi_cal[63:48]};
		p9 = {{16{p9_cal[15]}}, p9_cal};
		h1 = {24'b0, humid_cal[7:0]};
		h2 = {{16{humid_cal[23]}}, humid_cal[23:8]};
		h3 = {24'b0, humid_cal[31:24]};
		h4 = {{20{humid_cal[43]}}, humid_cal[43:32]};
		h5 = {{20{humid_cal[55]}}, humid_cal[55:44]};
		h6 = {{24{humid_cal[63]}}, humid_cal[63:56]};

		a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
		d = (at >> 4) - t1;
		b = sra(sra(d * d, 12) * t3, 14);
		tf = a + b;
		r.temperature_centi = 24'(sra(tf * 32'd5 + 32'd128, 8));

		x = tf - 32'd76800;
		a = sra((ah << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
		b = sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768);
		b = (sra(b, 10) + 32'd2097152) * h2 + 32'd8192;
		x = a * sra(b, 14);
		q = sra(x, 15);
		x = x - sra(sra(q * q, 7) * h1, 4);
		if (x[31])
			x = 0;
		if (x > 32'd419430400)
			x = 32'd419430400;
		r.humidity_q10 = 17'(x >> 12);

		a = sra(tf, 1) - 32'd64000;
		q = sra(a, 2);
		b = sra(q * q, 11) * p6;
		b = b + ((a * p5) << 1);
		b = sra(b, 2) + (p4 << 16);
		a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
		a = sra((32'd32768 + a) * p1, 15);
		if (a == 0) begin
			r.pressure_divisor_zero = 1'b1;
			pres = 0;
		end else begin
			r.pressure_divisor_zero = 1'b0;
			pres = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
			if (pres < 32'h80000000)
				pres = (pres << 1) / a;
			else
				pres = (pres / a) * 32'd2;
			a = sra(p9 * (((pres >> 3) * (pres >> 3)) >> 13), 12);
			b = sra((pres >> 2) * p8, 13);
			pres = pres + sra(a + b + p7, 4);
		end
		r.pressure_pa = pres;
		return r;
	endfunction

	// input side
	always @(posedge clk) begin
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				expected_results.push_back(compensate(cur_sample));
				busy = 0;
				send_gap = no_idle ? 0 : $urandom_range(0, 14);
			end
			if (!busy) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_samples.size() > 0) begin
					cur_sample = pending_samples.pop_front();
					raw_temperature <= cur_sample.raw_temperature;
					raw_pressure <= cur_sample.raw_pressure;
					raw_humidity <= cur_sample.raw_humidity;
					busy = 1;
				end
			end
			in_valid <= busy;
		end
	end

	// output side
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t unexpected transfer: temp %h hum %h pres %h dz %b", $time,
						temperature_centi, humidity_q10, pressure_pa, pressure_divisor_zero);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.temperature_centi !== temperature_centi) begin
						errors++;
						$display("%0t temperature_centi expected %h actual %h", $time,
							exp_r.temperature_centi, temperature_centi);
					end
					if (exp_r.humidity_q10 !== humidity_q10) begin
						errors++;
						$display("%0t humidity_q10 expected %h actual %h", $time,
							exp_r.humidity_q10, humidity_q10);
					end
					if (exp_r.pressure_pa !== pressure_pa) begin
						errors++;
						$display("%0t pressure_pa expected %h actual %h", $time,
							exp_r.pressure_pa, pressure_pa);
					end
					if (exp_r.pressure_divisor_zero !== pressure_divisor_zero) begin
						errors++;
						$display("%0t pressure_divisor_zero expected %b actual %b", $time,
							exp_r.pressure_divisor_zero, pressure_divisor_zero);
					end
				end
				recv_stall = no_idle ? 0 : $urandom_range(0, 14);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[pth_sensor_compensation] ERROR");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_calibration(input logic [47:0] tc, input logic [63:0] plo,
		input logic [63:0] phi, input logic [15:0] p9, input logic [63:0] hc);
		reg_write(REG_TEMP, {16'b0, tc});
		reg_write(REG_PRESS_LO, plo);
		reg_write(REG_PRESS_HI, phi);
		reg_write(REG_PRESS_P9, {48'b0, p9});
		reg_write(REG_HUMID, hc);
		temp_cal = tc;
		press_lo_cal = plo;
		press_hi_cal = phi;
		p9_cal = p9;
		humid_cal = hc;
	endtask

	task automatic add_sample(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
		sample_t s;
		s.raw_temperature = t;
		s.raw_pressure = p;
		s.raw_humidity = h;
		pending_samples.push_back(s);
	endtask

	task automatic add_random(input int n);
		repeat (n) begin
			if ($urandom_range(0, 3) != 0)
				add_sample(20'($urandom_range(380000, 620000)),
					20'($urandom_range(200000, 520000)),
					16'($urandom_range(15000, 55000)));
			else
				add_sample(20'($urandom), 20'($urandom), 16'($urandom));
		end
	endtask

	task automatic run_and_drain();
		wait (pending_samples.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	localparam logic [47:0] TYP_TEMP  = {16'hFC18, 16'd26435, 16'd27504};
	localparam logic [63:0] TYP_PLO   = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
	localparam logic [63:0] TYP_PHI   = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
	localparam logic [15:0] TYP_P9    = 16'd6000;
	localparam logic [63:0] TYP_HUMID = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

	initial begin
		temp_cal = '0;
		press_lo_cal = '0;
		press_hi_cal = '0;
		p9_cal = '0;
		humid_cal = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration: divisor is zero
		add_sample(20'd0, 20'd0, 16'd0);
		add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		add_random(20);
		run_and_drain();

		// typical calibration, directed corners
		load_calibration(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9, TYP_HUMID);
		add_sample(20'd519888, 20'd415148, 16'd30000);
		add_sample(20'd0, 20'd0, 16'd0);
		add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		add_sample(20'h80000, 20'h80000, 16'h8000);
		add_sample(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
		add_sample(20'd519888, 20'd0, 16'hFFFF);
		add_sample(20'd519888, 20'hFFFFF, 16'd0);
		add_sample(20'h55555, 20'hAAAAA, 16'h5555);
		add_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
		run_and_drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_calibration(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9, TYP_HUMID);
				1: load_calibration('1, '1, '1, '1, '1);
				2: load_calibration(TYP_TEMP, {TYP_PLO[63:16], 16'd0}, TYP_PHI, 16'h8000,
					TYP_HUMID);
				3: load_calibration(TYP_TEMP, TYP_PLO, TYP_PHI, 16'h7FFF,
					{8'h80, 12'h800, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
				default: load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
					{$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
			endcase
			no_idle = (ph % 3 == 1);
			add_random(N_RANDOM / 8);
			run_and_drain();
		end

		if (errors == 0)
			$display("[pth_sensor_compensation] OK");
		else
			$display("[pth_sensor_compensation] ERROR");
		$finish;
	end
endmodule
